### hw/rtl/bplp_pkg.sv
// Shared types, constants and helper functions of the ball position line parser.
package bplp_pkg;

  localparam int FRAC_DIGITS = 3;
  localparam int FRAC_W = $clog2(FRAC_DIGITS + 1);
  localparam int DIV_W = 35;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_L = 8'h4C;

  localparam logic [1:0] CFG_POSITION_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [1:0] CFG_SPEED_RESET_WINDOW = 2'd2;
  localparam logic [1:0] CFG_FILTER_GAIN = 2'd3;

  localparam logic [1:0] STATUS_INVALID = 2'd0;
  localparam logic [1:0] STATUS_MEASUREMENT = 2'd1;

  typedef enum logic [3:0] {
    PH_START, PH_DOLLAR, PH_DOLLAR_B, PH_B, PH_BA, PH_BAL, PH_BALL, PH_NUM_START,
    PH_NUM_SIGN, PH_NUM_INT, PH_FRAC_EMPTY, PH_FRAC, PH_STATUS_START, PH_STATUS,
    PH_DONE, PH_FAIL
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE, C_CHECK, C_PREP, C_DIV, C_JUDGE, C_FILT, C_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic restart;
    logic frame;
    logic timing;
    logic prep;
    logic div_step;
    logic mul;
    logic commit;
    logic use_filter;
    logic reject;
  } cmd_t;

  typedef struct packed {
    logic eol_byte;
    logic line_held;
    logic line_ok;
    logic is_meas;
    logic has_prev;
    logic need_div;
    logic div_last;
    logic too_fast;
  } status_t;

  function automatic logic [31:0] add_digit(input logic [31:0] a, input logic [3:0] d);
    logic [35:0] v;
    v = 36'(a) * 36'd10 + 36'(d);
    if (v > 36'hFFFFFFFF) v = 36'hFFFFFFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] scale_value(input logic [31:0] a,
                                              input logic [FRAC_W-1:0] f);
    logic [35:0] v;
    v = 36'(a);
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (int'(f) <= i) begin
        v = 36'(v[31:0]) * 36'd10;
        if (v > 36'hFFFFFFFF) v = 36'hFFFFFFFF;
      end
    end
    return v[31:0];
  endfunction

endpackage

### hw/rtl/bplp_ctrl.sv
// Controller state machine sequencing the line-end checks, division and filter.
module bplp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bplp_pkg::status_t  st,
  output bplp_pkg::cmd_t     cmd
);

  bplp_pkg::ctl_state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bplp_pkg::C_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    case (state)
      bplp_pkg::C_IDLE: begin
        in_ready = ~(out_valid & st.eol_byte);
        cmd.take = in_valid & in_ready;
        if (cmd.take && st.eol_byte && st.line_held) state_next = bplp_pkg::C_CHECK;
      end
      bplp_pkg::C_CHECK: begin
        if (!st.line_ok) begin
          cmd.restart = 1'b1;
          state_next = bplp_pkg::C_IDLE;
        end else begin
          cmd.frame = 1'b1;
          if (!st.is_meas) begin
            state_next = bplp_pkg::C_EMIT;
          end else begin
            cmd.timing = st.has_prev;
            if (st.has_prev && st.need_div) begin
              state_next = bplp_pkg::C_PREP;
            end else begin
              cmd.commit = 1'b1;
              state_next = bplp_pkg::C_EMIT;
            end
          end
        end
      end
      bplp_pkg::C_PREP: begin
        cmd.prep = 1'b1;
        state_next = bplp_pkg::C_DIV;
      end
      bplp_pkg::C_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = bplp_pkg::C_JUDGE;
      end
      bplp_pkg::C_JUDGE: begin
        if (st.too_fast) begin
          cmd.reject = 1'b1;
          state_next = bplp_pkg::C_EMIT;
        end else begin
          cmd.mul = 1'b1;
          state_next = bplp_pkg::C_FILT;
        end
      end
      bplp_pkg::C_FILT: begin
        cmd.commit = 1'b1;
        cmd.use_filter = 1'b1;
        state_next = bplp_pkg::C_EMIT;
      end
      bplp_pkg::C_EMIT: begin
        cmd.restart = 1'b1;
        out_valid_next = 1'b1;
        state_next = bplp_pkg::C_IDLE;
      end
      default: state_next = bplp_pkg::C_IDLE;
    endcase
  end

endmodule

### hw/rtl/bplp_datapath.sv
// Datapath: byte parser, configuration, divider, speed filter and statistics.
module bplp_datapath #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  bplp_pkg::cmd_t     cmd,
  output bplp_pkg::status_t  st,
  input  logic [7:0]         rx_byte,
  input  logic [31:0]        now_ms,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic signed [23:0] position,
  output logic signed [31:0] speed,
  output logic [1:0]         line_status,
  output logic [31:0]        frame_count,
  output logic [31:0]        interval,
  output logic [31:0]        max_interval,
  output logic [31:0]        accepted_count,
  output logic [31:0]        rejected_count,
  output logic               new_measurement
);

  localparam int CW = $clog2(LINE_CAPACITY);
  localparam int FW = bplp_pkg::FRAC_W;
  localparam int DW = bplp_pkg::DIV_W;

  logic [22:0] position_limit;
  logic [30:0] max_speed;
  logic [15:0] speed_reset_window;
  logic [16:0] filter_gain;

  bplp_pkg::phase_t phase, phase_n;
  logic [CW-1:0] char_count;
  logic [31:0] acc, acc_n;
  logic [FW-1:0] frac, frac_n;
  logic neg, neg_n, in_speed, in_speed_n;
  logic [31:0] pos_mag, pos_mag_n, spd_mag, spd_mag_n;
  logic pos_neg, pos_neg_n, spd_neg, spd_neg_n, spd_rep, spd_rep_n;
  logic [1:0] stat, stat_n;
  logic stat_big, stat_big_n;

  logic [7:0] c;
  logic e, is_digit, end_num, has_dig, eol;
  logic [3:0] d;
  logic [31:0] val, dig_acc;

  logic [31:0] now_l, prev_time, elapsed;
  logic signed [23:0] prev_pos, pos24;
  logic prev_valid;
  logic [DW-1:0] dq;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic [31:0] dvs;
  logic [bplp_pkg::DIV_CNT_W-1:0] dcnt;
  logic raw_neg;
  logic signed [24:0] diff;
  logic signed [34:0] prod_k;
  logic signed [31:0] raw32, spd_direct, spd_filt, spd_sel;
  logic signed [32:0] fdiff;
  logic signed [50:0] prod, pb, q;
  logic signed [51:0] fsum;

  assign eol = (rx_byte == bplp_pkg::CH_CR) || (rx_byte == bplp_pkg::CH_LF);

  always_comb begin
    c = rx_byte;
    e = eol || (rx_byte == bplp_pkg::CH_NUL);
    is_digit = !e && (c >= bplp_pkg::CH_0) && (c <= bplp_pkg::CH_9);
    d = is_digit ? 4'(c - bplp_pkg::CH_0) : 4'd0;
    val = bplp_pkg::scale_value(acc, frac);
    dig_acc = bplp_pkg::add_digit(acc, d);
    end_num = 1'b0;
    has_dig = 1'b0;
    phase_n = phase;
    acc_n = acc;
    frac_n = frac;
    neg_n = neg;
    in_speed_n = in_speed;
    pos_mag_n = pos_mag;
    pos_neg_n = pos_neg;
    spd_mag_n = spd_mag;
    spd_neg_n = spd_neg;
    spd_rep_n = spd_rep;
    stat_n = stat;
    stat_big_n = stat_big;
    case (phase)
      bplp_pkg::PH_START:
        phase_n = (!e && c == bplp_pkg::CH_DOLLAR) ? bplp_pkg::PH_DOLLAR :
                  (!e && c == bplp_pkg::CH_B) ? bplp_pkg::PH_B : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_DOLLAR:
        phase_n = (!e && c == bplp_pkg::CH_B) ? bplp_pkg::PH_DOLLAR_B : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_B:
        phase_n = (!e && c == bplp_pkg::CH_A) ? bplp_pkg::PH_BA : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_BA:
        phase_n = (!e && c == bplp_pkg::CH_L) ? bplp_pkg::PH_BAL : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_BAL:
        phase_n = (!e && c == bplp_pkg::CH_L) ? bplp_pkg::PH_BALL : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_DOLLAR_B, bplp_pkg::PH_BALL: begin
        if (!e && c == bplp_pkg::CH_COMMA) begin
          acc_n = '0;
          frac_n = '0;
          neg_n = 1'b0;
          phase_n = bplp_pkg::PH_NUM_START;
        end else begin
          phase_n = bplp_pkg::PH_FAIL;
        end
      end
      bplp_pkg::PH_NUM_START, bplp_pkg::PH_NUM_SIGN: begin
        if (phase == bplp_pkg::PH_NUM_START && !e &&
            (c == bplp_pkg::CH_MINUS || c == bplp_pkg::CH_PLUS)) begin
          neg_n = (c == bplp_pkg::CH_MINUS);
          phase_n = bplp_pkg::PH_NUM_SIGN;
        end else if (is_digit) begin
          acc_n = dig_acc;
          phase_n = bplp_pkg::PH_NUM_INT;
        end else if (!e && c == bplp_pkg::CH_DOT) begin
          phase_n = bplp_pkg::PH_FRAC_EMPTY;
        end else begin
          end_num = 1'b1;
        end
      end
      bplp_pkg::PH_NUM_INT: begin
        if (is_digit) begin
          acc_n = dig_acc;
        end else if (!e && c == bplp_pkg::CH_DOT) begin
          phase_n = bplp_pkg::PH_FRAC;
        end else begin
          end_num = 1'b1;
          has_dig = 1'b1;
        end
      end
      bplp_pkg::PH_FRAC_EMPTY, bplp_pkg::PH_FRAC: begin
        if (is_digit) begin
          if (frac < FW'(bplp_pkg::FRAC_DIGITS)) begin
            acc_n = dig_acc;
            frac_n = frac + 1'b1;
          end
          phase_n = bplp_pkg::PH_FRAC;
        end else begin
          end_num = 1'b1;
          has_dig = (phase == bplp_pkg::PH_FRAC);
        end
      end
      bplp_pkg::PH_STATUS_START: begin
        if (is_digit) begin
          acc_n = dig_acc;
          phase_n = bplp_pkg::PH_STATUS;
        end else begin
          phase_n = bplp_pkg::PH_FAIL;
        end
      end
      bplp_pkg::PH_STATUS: begin
        if (is_digit) begin
          acc_n = dig_acc;
        end else begin
          stat_n = acc[1:0];
          stat_big_n = (acc > 32'd2);
          if (!e && c == bplp_pkg::CH_COMMA) begin
            acc_n = '0;
            frac_n = '0;
            neg_n = 1'b0;
            in_speed_n = 1'b1;
            phase_n = bplp_pkg::PH_NUM_START;
          end else begin
            phase_n = bplp_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase
    if (end_num) begin
      if (!in_speed) begin
        if (has_dig && !e && c == bplp_pkg::CH_COMMA) begin
          pos_mag_n = val;
          pos_neg_n = neg;
          acc_n = '0;
          frac_n = '0;
          neg_n = 1'b0;
          phase_n = bplp_pkg::PH_STATUS_START;
        end else begin
          phase_n = bplp_pkg::PH_FAIL;
        end
      end else begin
        if (has_dig) begin
          spd_mag_n = val;
          spd_neg_n = neg;
          spd_rep_n = 1'b1;
        end
        phase_n = bplp_pkg::PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart ||
        (cmd.take && !eol && char_count >= CW'(LINE_CAPACITY - 1))) begin
      phase <= bplp_pkg::PH_START;
      acc <= '0;
      frac <= '0;
      neg <= 1'b0;
      in_speed <= 1'b0;
      pos_mag <= '0;
      pos_neg <= 1'b0;
      spd_mag <= '0;
      spd_neg <= 1'b0;
      spd_rep <= 1'b0;
      stat <= '0;
      stat_big <= 1'b0;
    end else if (cmd.take && (!eol || char_count != '0)) begin
      phase <= phase_n;
      acc <= acc_n;
      frac <= frac_n;
      neg <= neg_n;
      in_speed <= in_speed_n;
      pos_mag <= pos_mag_n;
      pos_neg <= pos_neg_n;
      spd_mag <= spd_mag_n;
      spd_neg <= spd_neg_n;
      spd_rep <= spd_rep_n;
      stat <= stat_n;
      stat_big <= stat_big_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (cmd.take) begin
      if (eol || char_count >= CW'(LINE_CAPACITY - 1)) char_count <= '0;
      else char_count <= char_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit <= 23'd200000;
      max_speed <= 31'd2000000;
      speed_reset_window <= 16'd100;
      filter_gain <= 17'd19661;
    end else if (cfg_write) begin
      case (cfg_index)
        bplp_pkg::CFG_POSITION_LIMIT: position_limit <= cfg_data[22:0];
        bplp_pkg::CFG_MAX_SPEED: max_speed <= cfg_data;
        bplp_pkg::CFG_SPEED_RESET_WINDOW: speed_reset_window <= cfg_data[15:0];
        bplp_pkg::CFG_FILTER_GAIN: filter_gain <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign pos24 = pos_neg ? -$signed(pos_mag[23:0]) : $signed(pos_mag[23:0]);
  assign elapsed = now_l - prev_time;
  assign diff = 25'(pos24) - 25'(prev_pos);
  assign prod_k = 35'(diff) * 35'sd1000;
  assign rem_sh = {rem, dq[DW-1]};
  assign raw32 = raw_neg ? -$signed(dq[31:0]) : $signed(dq[31:0]);
  assign fdiff = 33'(raw32) - 33'(speed);
  assign pb = prod + (prod[50] ? 51'sd65535 : 51'sd0);
  assign q = pb >>> 16;
  assign fsum = 52'(speed) + 52'(q);
  assign spd_filt = (fsum > 52'sd2147483647) ? 32'sh7FFFFFFF :
                    (fsum < -52'sd2147483648) ? 32'sh80000000 : fsum[31:0];
  assign spd_direct = !spd_rep ? 32'sd0 :
                      spd_neg ? -$signed(spd_mag) : $signed(spd_mag);
  assign spd_sel = cmd.use_filter ? spd_filt : spd_direct;

  always_comb begin
    st.eol_byte = eol;
    st.line_held = (char_count != '0);
    st.line_ok = (phase == bplp_pkg::PH_DONE) && !stat_big &&
                 (pos_mag <= 32'(position_limit)) &&
                 !(spd_rep && spd_mag > 32'(max_speed));
    st.is_meas = (stat == bplp_pkg::STATUS_MEASUREMENT);
    st.has_prev = prev_valid && (now_l != prev_time);
    st.need_div = !spd_rep && (elapsed <= 32'(speed_reset_window));
    st.div_last = (dcnt == bplp_pkg::DIV_CNT_W'(DW - 1));
    st.too_fast = (dq > DW'(max_speed));
  end

  always_ff @(posedge clk) begin
    if (cmd.take) now_l <= now_ms;
    if (cmd.prep) begin
      dq <= prod_k[34] ? DW'(-prod_k) : DW'(prod_k);
      raw_neg <= prod_k[34];
      dvs <= elapsed;
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= 32'(rem_sh - {1'b0, dvs});
        dq <= {dq[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        dq <= {dq[DW-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.mul) prod <= fdiff * $signed({1'b0, filter_gain});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos <= '0;
      prev_time <= '0;
      prev_valid <= 1'b0;
      speed <= '0;
      line_status <= '0;
      frame_count <= '0;
      interval <= '0;
      max_interval <= '0;
      accepted_count <= '0;
      rejected_count <= '0;
      new_measurement <= 1'b0;
    end else begin
      if (cmd.frame) begin
        line_status <= stat;
        frame_count <= frame_count + 1'b1;
      end
      if (cmd.frame || cmd.commit) new_measurement <= cmd.commit;
      if (cmd.timing) begin
        interval <= elapsed;
        if (elapsed > max_interval) max_interval <= elapsed;
      end
      if (cmd.reject) begin
        line_status <= bplp_pkg::STATUS_INVALID;
        rejected_count <= rejected_count + 1'b1;
      end
      if (cmd.commit) begin
        prev_pos <= pos24;
        prev_time <= now_l;
        prev_valid <= 1'b1;
        speed <= spd_sel;
        accepted_count <= accepted_count + 1'b1;
      end
    end
  end

  assign position = prev_pos;

endmodule

### hw/rtl/ball_position_line_parser.sv
// Top level of the ball position line parser.
// Usage: one received character (rx_byte) and the millisecond tick (now_ms)
// arrive per input word on a valid/ready channel. Ordinary characters are
// taken whenever the controller is idle and parsed on the fly. A CR or LF closes the line;
// a well-formed line within range produces one output word on the result
// channel carrying position, speed, status and the running statistics.
// From the line end, a line that needs no speed derivation goes through the
// check state and then the emit state; a measurement whose speed comes from
// the difference quotient goes through prepare, the bit-serial restoring
// divider, the speed judgement, then the filter multiply and commit.
// The block handles one line end at a time; characters keep flowing in
// while a result waits, but the next line end is held off until the
// receiver has taken the pending word. Configuration writes are taken in
// any cycle and belong in idle periods.
// Reset returns the parser to the start of a line, restores register
// defaults and clears all counters and the speed history.
module ball_position_line_parser #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] position,
  output logic signed [31:0] speed,
  output logic [1:0]         line_status,
  output logic [31:0]        frame_count,
  output logic [31:0]        interval,
  output logic [31:0]        max_interval,
  output logic [31:0]        accepted_count,
  output logic [31:0]        rejected_count,
  output logic               new_measurement,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  bplp_pkg::cmd_t cmd;
  bplp_pkg::status_t st;

  bplp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bplp_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .rx_byte         (rx_byte),
    .now_ms          (now_ms),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .position        (position),
    .speed           (speed),
    .line_status     (line_status),
    .frame_count     (frame_count),
    .interval        (interval),
    .max_interval    (max_interval),
    .accepted_count  (accepted_count),
    .rejected_count  (rejected_count),
    .new_measurement (new_measurement)
  );

  a_no_take_while_dividing: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ready)
    else $error("Input word accepted while the divider is running.");

  a_fresh_is_measurement: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_measurement) |-> (line_status == bplp_pkg::STATUS_MEASUREMENT))
    else $error("New measurement flagged on a line that is not a measurement.");

  a_line_end_waits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (rx_byte == bplp_pkg::CH_CR || rx_byte == bplp_pkg::CH_LF))
      |-> !out_valid)
    else $error("Line end accepted while a result word is pending.");

endmodule

### tb/ball_position_line_parser_checker.sv
// Checker for the ball position line parser: predicts each result word and compares it.
module ball_position_line_parser_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic [31:0]        now_ms,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] position,
  input  logic signed [31:0] speed,
  input  logic [1:0]         line_status,
  input  logic [31:0]        frame_count,
  input  logic [31:0]        interval,
  input  logic [31:0]        max_interval,
  input  logic [31:0]        accepted_count,
  input  logic [31:0]        rejected_count,
  input  logic               new_measurement,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output int                 failures,
  output int                 pending,
  output int                 words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAP = 64;
  localparam int END_TEXT = 256;
  localparam longint unsigned SAT = 64'hFFFFFFFF;

  typedef struct {
    logic [23:0] pos;
    logic [31:0] spd;
    logic [1:0]  st;
    logic [31:0] frames;
    logic [31:0] intv;
    logic [31:0] maxi;
    logic [31:0] acc;
    logic [31:0] rej;
    logic        fresh;
  } fix_t;

  fix_t expected_fixes[$];

  int unsigned lim, vmax, win, gain;
  bplp_pkg::phase_t ph;
  int unsigned nchar;
  longint unsigned digits;
  int fdig;
  bit neg, in_spd, spd_rep, prev_ok;
  longint ppos, rspd;
  int unsigned pstat;
  int prev_pos;
  int unsigned prev_t;
  int filt;
  int unsigned frames, intv, maxi, acc_cnt, rej_cnt, last_st;

  assign pending = expected_fixes.size();

  task automatic clear_number();
    digits = 0;
    fdig = 0;
    neg = 0;
  endtask

  task automatic clear_line();
    ph = bplp_pkg::PH_START;
    clear_number();
    in_spd = 0;
    ppos = 0;
    pstat = 0;
    rspd = 0;
    spd_rep = 0;
  endtask

  task automatic push_digit(int d);
    longint unsigned v;
    v = digits * 10 + d;
    digits = (v > SAT) ? SAT : v;
  endtask

  function automatic longint scaled();
    longint unsigned v;
    v = digits;
    for (int i = fdig; i < bplp_pkg::FRAC_DIGITS; i++) begin
      v = v * 10;
      if (v > SAT) v = SAT;
    end
    return neg ? -longint'(v) : longint'(v);
  endfunction

  task automatic close_number(bit has, int c);
    if (!in_spd) begin
      if (has && c == bplp_pkg::CH_COMMA) begin
        ppos = scaled();
        clear_number();
        ph = bplp_pkg::PH_STATUS_START;
      end else begin
        ph = bplp_pkg::PH_FAIL;
      end
    end else begin
      if (has) begin
        rspd = scaled();
        spd_rep = 1;
      end
      ph = bplp_pkg::PH_DONE;
    end
  endtask

  task automatic parse_char(int c);
    bit dig;
    dig = (c >= bplp_pkg::CH_0 && c <= bplp_pkg::CH_9);
    case (ph)
      bplp_pkg::PH_START:
        ph = (c == bplp_pkg::CH_DOLLAR) ? bplp_pkg::PH_DOLLAR :
             (c == bplp_pkg::CH_B) ? bplp_pkg::PH_B : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_DOLLAR:
        ph = (c == bplp_pkg::CH_B) ? bplp_pkg::PH_DOLLAR_B : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_B: ph = (c == bplp_pkg::CH_A) ? bplp_pkg::PH_BA : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_BA: ph = (c == bplp_pkg::CH_L) ? bplp_pkg::PH_BAL : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_BAL: ph = (c == bplp_pkg::CH_L) ? bplp_pkg::PH_BALL : bplp_pkg::PH_FAIL;
      bplp_pkg::PH_DOLLAR_B, bplp_pkg::PH_BALL: begin
        if (c == bplp_pkg::CH_COMMA) begin
          clear_number();
          ph = bplp_pkg::PH_NUM_START;
        end else begin
          ph = bplp_pkg::PH_FAIL;
        end
      end
      bplp_pkg::PH_NUM_START, bplp_pkg::PH_NUM_SIGN: begin
        if (ph == bplp_pkg::PH_NUM_START &&
            (c == bplp_pkg::CH_MINUS || c == bplp_pkg::CH_PLUS)) begin
          neg = (c == bplp_pkg::CH_MINUS);
          ph = bplp_pkg::PH_NUM_SIGN;
        end else if (dig) begin
          push_digit(c - bplp_pkg::CH_0);
          ph = bplp_pkg::PH_NUM_INT;
        end else if (c == bplp_pkg::CH_DOT) begin
          ph = bplp_pkg::PH_FRAC_EMPTY;
        end else begin
          close_number(0, c);
        end
      end
      bplp_pkg::PH_NUM_INT: begin
        if (dig) push_digit(c - bplp_pkg::CH_0);
        else if (c == bplp_pkg::CH_DOT) ph = bplp_pkg::PH_FRAC;
        else close_number(1, c);
      end
      bplp_pkg::PH_FRAC_EMPTY, bplp_pkg::PH_FRAC: begin
        if (dig) begin
          if (fdig < bplp_pkg::FRAC_DIGITS) begin
            push_digit(c - bplp_pkg::CH_0);
            fdig++;
          end
          ph = bplp_pkg::PH_FRAC;
        end else begin
          close_number(ph == bplp_pkg::PH_FRAC, c);
        end
      end
      bplp_pkg::PH_STATUS_START: begin
        if (dig) begin
          push_digit(c - bplp_pkg::CH_0);
          ph = bplp_pkg::PH_STATUS;
        end else begin
          ph = bplp_pkg::PH_FAIL;
        end
      end
      bplp_pkg::PH_STATUS: begin
        if (dig) begin
          push_digit(c - bplp_pkg::CH_0);
        end else begin
          pstat = digits[31:0];
          if (c == bplp_pkg::CH_COMMA) begin
            clear_number();
            in_spd = 1;
            ph = bplp_pkg::PH_NUM_START;
          end else begin
            ph = bplp_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic close_line(int unsigned now);
    longint spd, raw, prod;
    int unsigned elapsed;
    bit rejected, fresh, in_win;
    fix_t f;
    fresh = 0;
    if (ph != bplp_pkg::PH_DONE) return;
    if (pstat > 2 || mag(ppos) > longint'(lim)) return;
    if (spd_rep && mag(rspd) > longint'(vmax)) return;
    last_st = pstat;
    frames++;
    if (pstat == 1) begin
      spd = spd_rep ? rspd : 0;
      rejected = 0;
      if (prev_ok && now != prev_t) begin
        elapsed = now - prev_t;
        in_win = elapsed <= win;
        raw = (ppos - longint'(prev_pos)) * 1000 / longint'(elapsed);
        intv = elapsed;
        if (elapsed > maxi) maxi = elapsed;
        if (!spd_rep && in_win && mag(raw) > longint'(vmax)) begin
          last_st = 0;
          rej_cnt++;
          rejected = 1;
        end else if (!spd_rep && in_win) begin
          prod = (raw - longint'(filt)) * longint'(gain);
          spd = longint'(filt) + prod / 65536;
          if (spd > 64'sd2147483647) spd = 64'sd2147483647;
          if (spd < -64'sd2147483648) spd = -64'sd2147483648;
        end
      end
      if (!rejected) begin
        prev_pos = int'(ppos);
        prev_t = now;
        prev_ok = 1;
        filt = int'(spd);
        acc_cnt++;
        fresh = 1;
      end
    end
    f.pos = prev_pos[23:0];
    f.spd = filt;
    f.st = last_st[1:0];
    f.frames = frames;
    f.intv = intv;
    f.maxi = maxi;
    f.acc = acc_cnt;
    f.rej = rej_cnt;
    f.fresh = fresh;
    expected_fixes.push_back(f);
  endtask

  task automatic take_byte(logic [7:0] c, int unsigned now);
    if (c == bplp_pkg::CH_LF || c == bplp_pkg::CH_CR) begin
      if (nchar != 0) begin
        parse_char(END_TEXT);
        close_line(now);
      end
      clear_line();
      nchar = 0;
    end else if (nchar < LINE_CAP - 1) begin
      nchar++;
      parse_char((c == bplp_pkg::CH_NUL) ? END_TEXT : int'(c));
    end else begin
      nchar = 0;
      clear_line();
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    fix_t f;
    if (rst) begin
      failures = 0;
      words_seen = 0;
      lim = 200000;
      vmax = 2000000;
      win = 100;
      gain = 19661;
      clear_line();
      nchar = 0;
      prev_pos = 0;
      prev_t = 0;
      prev_ok = 0;
      filt = 0;
      frames = 0;
      intv = 0;
      maxi = 0;
      acc_cnt = 0;
      rej_cnt = 0;
      last_st = 0;
      expected_fixes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bplp_pkg::CFG_POSITION_LIMIT: lim = cfg_data[22:0];
          bplp_pkg::CFG_MAX_SPEED: vmax = cfg_data[30:0];
          bplp_pkg::CFG_SPEED_RESET_WINDOW: win = cfg_data[15:0];
          bplp_pkg::CFG_FILTER_GAIN: gain = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_byte(rx_byte, now_ms);
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_fixes.size() == 0) begin
          report("unexpected word, frame_count", frame_count, -1);
        end else begin
          f = expected_fixes.pop_front();
          if (position !== f.pos) report("position", position, $signed(f.pos));
          if (speed !== f.spd) report("speed", speed, $signed(f.spd));
          if (line_status !== f.st) report("line_status", line_status, f.st);
          if (frame_count !== f.frames) report("frame_count", frame_count, f.frames);
          if (interval !== f.intv) report("interval", interval, f.intv);
          if (max_interval !== f.maxi) report("max_interval", max_interval, f.maxi);
          if (accepted_count !== f.acc) report("accepted_count", accepted_count, f.acc);
          if (rejected_count !== f.rej) report("rejected_count", rejected_count, f.rej);
          if (new_measurement !== f.fresh)
            report("new_measurement", new_measurement, f.fresh);
        end
      end
    end
  end
endmodule

### tb/testbench.sv
// Top of the ball position line parser testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic [31:0]        now_ms;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] position;
  logic signed [31:0] speed;
  logic [1:0]         line_status;
  logic [31:0]        frame_count;
  logic [31:0]        interval;
  logic [31:0]        max_interval;
  logic [31:0]        accepted_count;
  logic [31:0]        rejected_count;
  logic               new_measurement;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [30:0]        cfg_data;
  int                 failures;
  int                 pending;
  int                 words_seen;

  int unsigned tick;
  longint      last_pos;
  int          burst_left;
  int          sent;
  int          stall_mode;
  int          stall_cycles;

  ball_position_line_parser i_dut (.*);

  ball_position_line_parser_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("ball_position_line_parser: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_mode <= 0;
      stall_cycles <= 0;
      out_ready <= 1'b0;
    end else begin
      if (stall_cycles == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_cycles <= $urandom_range(20, 300);
      end else begin
        stall_cycles <= stall_cycles - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_word(logic [7:0] b);
    logic taken;
    rx_byte <= b;
    now_ms <= tick;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic send_line(string s, int unsigned dt);
    tick += dt;
    send_text(s);
    send_word($urandom_range(0, 1) ? bplp_pkg::CH_LF : bplp_pkg::CH_CR);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_regs(int unsigned lim, int unsigned vmax, int unsigned win,
                           int unsigned gain);
    write_reg(bplp_pkg::CFG_POSITION_LIMIT, 31'(lim));
    write_reg(bplp_pkg::CFG_MAX_SPEED, 31'(vmax));
    write_reg(bplp_pkg::CFG_SPEED_RESET_WINDOW, 31'(win));
    write_reg(bplp_pkg::CFG_FILTER_GAIN, 31'(gain));
  endtask

  function automatic string milli_text(longint v);
    string s;
    longint a;
    a = (v < 0) ? -v : v;
    s = (v < 0) ? "-" : (($urandom_range(0, 3) == 0) ? "+" : "");
    if (a % 1000 == 0 && $urandom_range(0, 1)) return $sformatf("%s%0d", s, a / 1000);
    s = $sformatf("%s%0d.%03d", s, a / 1000, a % 1000);
    if ($urandom_range(0, 4) == 0) s = $sformatf("%s%0d", s, $urandom_range(0, 99));
    return s;
  endfunction

  task automatic random_line();
    int r, n;
    int unsigned dt;
    longint p;
    string s;
    r = $urandom_range(0, 99);
    dt = $urandom_range(1, 60);
    if ($urandom_range(0, 19) == 0) dt = 0;
    else if ($urandom_range(0, 9) == 0) dt = $urandom_range(61, 400);
    else if ($urandom_range(0, 19) == 0) dt = $urandom;
    if (r < 8) begin
      n = $urandom_range(1, 10);
      repeat (n) send_word(8'($urandom_range(0, 255)));
      send_word(bplp_pkg::CH_LF);
    end else if (r < 11) begin
      n = $urandom_range(60, 70);
      repeat (n) send_word(8'($urandom_range(8'h20, 8'h7E)));
      send_line("$B,1.5,1", dt);
    end else if (r < 14) begin
      send_word(bplp_pkg::CH_CR);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) p = 0;
      else if (r < 85) p = last_pos + $signed($urandom_range(0, 50000)) - 25000;
      else p = $signed($urandom_range(0, 500000)) - 250000;
      last_pos = p;
      s = $urandom_range(0, 1) ? "$B," : "BALL,";
      s = {s, ($urandom_range(0, 29) == 0) ? "99999999999" : milli_text(p), ","};
      r = $urandom_range(0, 99);
      s = {s, (r < 80) ? "1" : (r < 88) ? "0" : (r < 96) ? "2" : "3"};
      if ($urandom_range(0, 3) == 0)
        s = {s, ",", milli_text($signed($urandom_range(0, 4000000)) - 2000000)};
      if ($urandom_range(0, 19) == 0)
        s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 29) == 0) begin
        send_text(s);
        send_word(bplp_pkg::CH_NUL);
        s = "junk";
      end
      send_line(s, dt);
    end
  endtask

  task automatic random_phase(int bytes, int words);
    int start_sent, start_words;
    start_sent = sent;
    start_words = words_seen + pending;
    while (sent - start_sent < bytes || words_seen + pending - start_words < words)
      random_line();
    settle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    now_ms = '0;
    cfg_write = 1'b0;
    cfg_index = bplp_pkg::CFG_POSITION_LIMIT;
    cfg_data = '0;
    burst_left = 0;
    sent = 0;
    last_pos = 0;
    tick = 32'hFFFF_FFF0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_line("$B,0,1", 0);
    send_line("BALL,0.2,1,1.5", 8);
    send_line("$B,+1.23456,1", 10);
    send_line("$B,1.3,1", 0);
    send_line("$B,-199.999,2", 5);
    send_line("$B,200,0", 5);
    send_line("$B,200.001,1", 5);
    send_line("$B,99999999999,1", 5);
    send_line("$B,1,7", 5);
    send_line("$B,1,99999999999", 5);
    send_word(bplp_pkg::CH_LF);
    send_text("$B,2,1");
    send_word(bplp_pkg::CH_NUL);
    send_line(",junk", 5);
    repeat (70) send_word("x");
    send_line("$B,2.1,1", 5);
    send_line("$B,.5,1", 5);
    send_line("$B,.,1", 5);
    send_line("$B,1,1,", 5);
    send_line("$B,1,1,5x", 5);
    send_line("$B,1,1a", 5);
    send_line("$X,1,1", 5);
    send_line("$B,150,1", 2);
    send_line("$B,151,1", 500);
    send_line("$B,-3,1,-2000.001", 5);
    settle();

    random_phase(80, 4);
    load_regs(32'h7FFFFF, 32'h7FFFFFFF, 32'hFFFF, 32'h10000);
    random_phase(80, 4);
    load_regs(0, 0, 0, 0);
    random_phase(80, 2);
    load_regs(300000, 500000, 50, 32768);
    random_phase(80, 4);

    if (failures == 0 && pending == 0) begin
      $display("ball_position_line_parser: match");
    end else begin
      $display("ball_position_line_parser: mismatch");
    end
    $finish;
  end
endmodule
